FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the gene ring stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/grs_pkg.sv
// Package with constants, arithmetic helpers and the sigmoid table of the gene ring stepper.
package grs_pkg;

    localparam int MAX_GENES        = 8;
    localparam int SIGMOID_SEGMENTS = 256;
    localparam int GENE_W           = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
    localparam int GENE_CNT_W       = $clog2(MAX_GENES + 1);
    localparam int SEG_BITS         = $clog2(SIGMOID_SEGMENTS);

    // Register indexes of the configuration port.
    localparam logic [3:0] REG_GENES  = 4'd0;
    localparam logic [3:0] REG_ACT    = 4'd1;
    localparam logic [3:0] REG_REPR   = 4'd2;
    localparam logic [3:0] REG_BOUND  = 4'd3;
    localparam logic [3:0] REG_EXPR   = 4'd4;
    localparam logic [3:0] REG_DECAY  = 4'd5;
    localparam logic [3:0] REG_DT     = 4'd6;
    localparam logic [3:0] REG_START  = 4'd7;

    // Item opcodes.
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam longint unsigned ONE_Q31 = 64'd2147483648;
    localparam longint unsigned ONE_Q24 = 64'd16777216;

    typedef logic [31:0] sig_table_t [0:SIGMOID_SEGMENTS];

    // Unsigned quotient by shift and subtract, used while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-f in Q1.31 by a Taylor series with floored terms.
    function automatic longint unsigned exp_neg_frac(input longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        int k;
        logic done;
        sum  = ONE_Q31;
        term = ONE_Q31;
        done = 1'b0;
        for (k = 1; k < 40; k++) begin
            if (!done) begin
                term = div_u64((term * f) >> 31, longint'(k));
                if (term == 0) begin
                    done = 1'b1;
                end else if ((k % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic longint unsigned mul_q31(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Sigmoid samples at -8 + 16*j/SIGMOID_SEGMENTS in Q8.24.
    function automatic sig_table_t build_sig_table();
        sig_table_t tab;
        longint unsigned e1;
        longint unsigned num;
        longint unsigned whole;
        longint unsigned rem;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        int d;
        int j;
        int i;
        e1 = exp_neg_frac(ONE_Q31);
        for (j = 0; j <= SIGMOID_SEGMENTS; j++) begin
            d     = 2 * j - SIGMOID_SEGMENTS;
            num   = longint'(8 * ((d < 0) ? -d : d));
            whole = num / SIGMOID_SEGMENTS;
            rem   = num % SIGMOID_SEGMENTS;
            e     = exp_neg_frac((rem << 31) / SIGMOID_SEGMENTS);
            for (i = 0; i < int'(whole); i++) begin
                e = mul_q31(e, e1);
            end
            den = ONE_Q31 + e;
            s   = div_u64((64'd1 << 55) + den / 2, den);
            tab[j] = 32'((d < 0) ? (ONE_Q24 - s) : s);
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

    // Q8.24 product rounding: add half, floor by 2^24.
    function automatic logic signed [39:0] round_q24(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd8388608;
        return 40'(t >>> 24);
    endfunction

    // Interpolation rounding: add half, floor by 2^28 (non-negative product).
    function automatic logic [31:0] round_q28(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd134217728;
        return 32'(t >>> 28);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

FILE: rtl/grs_mul.sv
// Shared signed 32 by 32 multiplier with a registered product.
module grs_mul (
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    // The product is payload and takes no reset.
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/gene_ring_euler_step_core.sv
// Top level of the gene ring Euler stepper: sequencer, gene stores and configuration.
// An init item sets the potential and level stores when it is accepted; a step item walks
// every active gene through the velocity states (S_LOAD to S_DX), then every active gene
// through the update states (S_UA to S_UC), all products going one at a time through a
// single registered 32x32 multiplier. With emit_state set, one result item per active gene
// follows, one per cycle when out_stall is low. The input is stalled until the item and its report are done.
`include "assert_macros.svh"

module gene_ring_euler_step_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic               emit_state,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         gene_index,
    output logic signed [31:0] potential_value,
    output logic signed [31:0] level_value,
    output logic               last_gene,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_LOAD = 14'b00000000000010,
        S_PREV = 14'b00000000000100,
        S_MRX  = 14'b00000000001000,
        S_MHU  = 14'b00000000010000,
        S_MSIG = 14'b00000000100000,
        S_MDU  = 14'b00000001000000,
        S_MGS  = 14'b00000010000000,
        S_MKX  = 14'b00000100000000,
        S_DX   = 14'b00001000000000,
        S_UA   = 14'b00010000000000,
        S_UB   = 14'b00100000000000,
        S_UC   = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } state_t;

    localparam int GW = grs_pkg::GENE_W;
    localparam int CW = grs_pkg::GENE_CNT_W;
    localparam int SB = grs_pkg::SEG_BITS;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [3:0]         genes_reg;
    logic [30:0]        act_reg;
    logic [30:0]        repr_reg;
    logic [30:0]        bound_reg;
    logic [30:0]        expr_reg;
    logic [30:0]        decay_reg;
    logic [30:0]        dt_reg;
    logic signed [31:0] start_reg;

    // Gene stores.
    logic signed [31:0] u_mem  [grs_pkg::MAX_GENES];
    logic signed [31:0] x_mem  [grs_pkg::MAX_GENES];
    logic signed [31:0] du_mem [grs_pkg::MAX_GENES];
    logic signed [31:0] dx_mem [grs_pkg::MAX_GENES];

    // Working registers.
    logic [CW-1:0]      gi_reg;
    logic               emit_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] xp_reg;
    logic signed [41:0] acc_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        diff_reg;
    logic [27:0]        frac_reg;
    logic               below_reg;
    logic               above_reg;
    logic [31:0]        sig_reg;

    // Output registers.
    logic               out_valid_reg;
    logic [2:0]         gene_index_reg;
    logic signed [31:0] pot_out_reg;
    logic signed [31:0] lvl_out_reg;
    logic               last_reg;

    logic [CW-1:0]      n_genes;
    logic [GW-1:0]      gidx;
    logic [GW-1:0]      pidx;
    logic               last_idx;
    logic               accept;
    logic               out_load;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [39:0] prod_q24;
    logic signed [32:0] off_full;
    logic [27:0]        off;
    logic [SB-1:0]      seg_idx;
    logic [SB:0]        seg_idx_hi;

    // Active gene count: zero acts as one, too many acts as the maximum.
    always_comb
    begin
        if (genes_reg == 4'd0) begin
            n_genes = CW'(1);
        end else if (32'(genes_reg) > grs_pkg::MAX_GENES) begin
            n_genes = CW'(grs_pkg::MAX_GENES);
        end else begin
            n_genes = CW'(genes_reg);
        end
    end

    assign gidx     = gi_reg[GW-1:0];
    assign pidx     = (gi_reg == '0) ? GW'(n_genes - CW'(1)) : GW'(gi_reg - CW'(1));
    assign last_idx = (gi_reg == n_genes - CW'(1));
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // Sigmoid segment and fraction from the loaded potential.
    assign off_full   = 33'(u_reg) + 33'sd134217728;
    assign off        = off_full[27:0];
    assign seg_idx    = off[27:28-SB];
    assign seg_idx_hi = {1'b0, seg_idx} + (SB+1)'(1);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MRX:
            begin
                mul_a = $signed({1'b0, repr_reg});
                mul_b = xp_reg;
            end
            S_MHU:
            begin
                mul_a = $signed({1'b0, bound_reg});
                mul_b = u_reg;
            end
            S_MSIG:
            begin
                mul_a = $signed(diff_reg);
                mul_b = $signed({4'b0, frac_reg});
            end
            S_MGS:
            begin
                mul_a = $signed({1'b0, expr_reg});
                mul_b = $signed(sig_reg);
            end
            S_MKX:
            begin
                mul_a = $signed({1'b0, decay_reg});
                mul_b = x_reg;
            end
            S_UA:
            begin
                mul_a = du_mem[gidx];
                mul_b = $signed({1'b0, dt_reg});
            end
            S_UB:
            begin
                mul_a = dx_mem[gidx];
                mul_b = $signed({1'b0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    grs_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_q24 = grs_pkg::round_q24(prod);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            genes_reg <= 4'd3;
            act_reg   <= 31'd1677722;
            repr_reg  <= 31'd1677722;
            bound_reg <= 31'd83886;
            expr_reg  <= 31'd33554432;
            decay_reg <= 31'd8388608;
            dt_reg    <= 31'd16777;
            start_reg <= 32'sd16777216;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                grs_pkg::REG_GENES: genes_reg <= cfg_data[3:0];
                grs_pkg::REG_ACT:   act_reg   <= cfg_data[30:0];
                grs_pkg::REG_REPR:  repr_reg  <= cfg_data[30:0];
                grs_pkg::REG_BOUND: bound_reg <= cfg_data[30:0];
                grs_pkg::REG_EXPR:  expr_reg  <= cfg_data[30:0];
                grs_pkg::REG_DECAY: decay_reg <= cfg_data[30:0];
                grs_pkg::REG_DT:    dt_reg    <= cfg_data[30:0];
                grs_pkg::REG_START: start_reg <= $signed(cfg_data);
                default:            ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (opcode == grs_pkg::OP_STEP) begin
                        state_next = S_LOAD;
                    end else if (emit_state) begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_LOAD: state_next = S_PREV;
            S_PREV: state_next = S_MRX;
            S_MRX:  state_next = S_MHU;
            S_MHU:  state_next = S_MSIG;
            S_MSIG: state_next = S_MDU;
            S_MDU:  state_next = S_MGS;
            S_MGS:  state_next = S_MKX;
            S_MKX:  state_next = S_DX;
            S_DX:   state_next = last_idx ? S_UA : S_LOAD;
            S_UA:   state_next = S_UB;
            S_UB:   state_next = S_UC;
            S_UC:
            begin
                if (last_idx) begin
                    state_next = emit_reg ? S_EMIT : S_IDLE;
                end else begin
                    state_next = S_UA;
                end
            end
            S_EMIT:
            begin
                if (out_load && last_idx) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            gi_reg    <= '0;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                gi_reg   <= '0;
                emit_reg <= emit_state;
            end else if (state_reg == S_DX || state_reg == S_UC || out_load) begin
                gi_reg <= last_idx ? '0 : gi_reg + CW'(1);
            end
        end
    end

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:
            begin
                u_reg <= u_mem[gidx];
                x_reg <= x_mem[gidx];
            end
            S_PREV:
            begin
                xp_reg    <= x_mem[pidx];
                lo_reg    <= grs_pkg::SIG_TABLE[seg_idx];
                diff_reg  <= grs_pkg::SIG_TABLE[seg_idx_hi] - grs_pkg::SIG_TABLE[seg_idx];
                frac_reg  <= {off[27-SB:0], SB'(0)};
                below_reg <= (u_reg < -32'sd134217728);
                above_reg <= (u_reg >= 32'sd134217728);
            end
            S_MHU:  acc_reg <= 42'($signed({1'b0, act_reg})) - 42'(prod_q24);
            S_MSIG: acc_reg <= acc_reg - 42'(prod_q24);
            S_MDU:
            begin
                if (below_reg) begin
                    sig_reg <= '0;
                end else if (above_reg) begin
                    sig_reg <= 32'(grs_pkg::ONE_Q24);
                end else begin
                    sig_reg <= lo_reg + grs_pkg::round_q28(prod);
                end
            end
            S_MKX:  acc_reg <= 42'(prod_q24);
            default: ;
        endcase
    end

    // Potential and level stores: cleared by reset; an init item loads the start potential into gene zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < grs_pkg::MAX_GENES; i++) begin
                u_mem[i] <= '0;
                x_mem[i] <= '0;
            end
        end else if (accept && opcode == grs_pkg::OP_INIT) begin
            for (int i = 0; i < grs_pkg::MAX_GENES; i++) begin
                u_mem[i] <= (i == 0) ? start_reg : 32'sd0;
                x_mem[i] <= '0;
            end
        end else if (state_reg == S_UB) begin
            u_mem[gidx] <= grs_pkg::sat32(42'(u_mem[gidx]) + 42'(prod_q24));
        end else if (state_reg == S_UC) begin
            x_mem[gidx] <= grs_pkg::sat32(42'(x_mem[gidx]) + 42'(prod_q24));
        end
    end

    // Velocity stores: always written before they are read.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MDU) begin
            du_mem[gidx] <= grs_pkg::sat32(acc_reg);
        end
        if (state_reg == S_DX) begin
            dx_mem[gidx] <= grs_pkg::sat32(acc_reg - 42'(prod_q24));
        end
    end

    // Result item register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            gene_index_reg <= 3'(gi_reg);
            pot_out_reg    <= u_mem[gidx];
            lvl_out_reg    <= x_mem[gidx];
            last_reg       <= last_idx;
        end
    end

    assign out_valid       = out_valid_reg;
    assign gene_index      = gene_index_reg;
    assign potential_value = pot_out_reg;
    assign level_value     = lvl_out_reg;
    assign last_gene       = last_reg;

    // The gene counter stays within the ring while genes are walked.
    `ASSERT_IMPLIES(a_gene_in_ring, clk, rst_n, state_reg != S_IDLE, gi_reg < n_genes)
    // A report ends on the last active gene.
    `ASSERT_IMPLIES(a_last_gene, clk, rst_n, out_valid && last_gene, gene_index == 3'(n_genes - CW'(1)))
    // An init item loads the start potential into gene zero.
    `ASSERT_NEXT(a_init_load, clk, rst_n, accept && opcode == grs_pkg::OP_INIT, u_mem[0] == $past(start_reg))

endmodule
